// File: rtl/mavg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average package
// Shared constants, controller states and command/status groups.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // default sizes and configuration register layout
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_LEN_BITS    = 7;
  localparam logic [CFG_LEN_BITS-1:0] LEN_RESET = 7'd8;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_DIVIDE,
    ST_OUTPUT
  } mavg_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic setup;
    logic div_step;
    logic out_load;
  } mavg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_busy;
  } mavg_status_t;

endpackage
`default_nettype wire

// File: rtl/mavg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average controller
// Sequences one request through ring update, divider and output register.
// ----------------------------------------------------------------------------
module mavg_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire mavg_pkg::mavg_status_t status,
  output mavg_pkg::mavg_cmd_t   cmd
);

  mavg_pkg::mavg_state_t state_r;
  mavg_pkg::mavg_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      mavg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = mavg_pkg::ST_UPDATE;
        end
      end
      mavg_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = mavg_pkg::ST_SETUP;
      end
      mavg_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = mavg_pkg::ST_DIVIDE;
      end
      mavg_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = mavg_pkg::ST_OUTPUT;
        end
      end
      mavg_pkg::ST_OUTPUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = mavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mavg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/mavg_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average datapath
// Sample ring, running sum, fill count, bit-serial divider, output register.
// ----------------------------------------------------------------------------
module mavg_dp #(
  parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_valid,
  input  wire  [mavg_pkg::CFG_LEN_BITS-1:0]    cfg_window_length,
  input  wire  signed [SAMPLE_BITS-1:0]        in_sample,
  output logic signed [SAMPLE_BITS-1:0]        out_average,
  output logic                                 out_window_full,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  input  wire  mavg_pkg::mavg_cmd_t            cmd,
  output mavg_pkg::mavg_status_t               status
);

  localparam int PTR_BITS  = $clog2(WINDOW_MAX);
  localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS);
  localparam int CMP_BITS  = (CNT_BITS > mavg_pkg::CFG_LEN_BITS) ?
                             CNT_BITS : mavg_pkg::CFG_LEN_BITS;

  // zero reads as one, above the ring depth saturates
  function automatic logic [CNT_BITS-1:0] eff_len(
    input logic [mavg_pkg::CFG_LEN_BITS-1:0] raw
  );
    logic [CMP_BITS-1:0] wide;
    wide = CMP_BITS'(raw);
    if (wide == '0) begin
      eff_len = CNT_BITS'(1);
    end else if (wide > CMP_BITS'(WINDOW_MAX)) begin
      eff_len = CNT_BITS'(WINDOW_MAX);
    end else begin
      eff_len = CNT_BITS'(wide);
    end
  endfunction

  logic [SAMPLE_BITS-1:0]     ring_mem [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]     rd_data_r;
  logic [SAMPLE_BITS-1:0]     sample_r;
  logic [CNT_BITS-1:0]        len_r;
  logic [PTR_BITS-1:0]        ptr_r;
  logic [CNT_BITS-1:0]        fill_r;
  logic signed [SUM_BITS-1:0] sum_r;
  logic signed [SUM_BITS-1:0] sum_nxt;
  logic [SUM_BITS-1:0]        quo_r;
  logic [CNT_BITS-1:0]        rem_r;
  logic [STEP_BITS-1:0]       step_r;
  logic                       neg_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_average_r;
  logic                       out_full_r;
  logic                       full;
  logic [CNT_BITS-1:0]        ptr_inc;
  logic signed [SUM_BITS-1:0] new_ext;
  logic signed [SUM_BITS-1:0] old_ext;
  logic [CNT_BITS:0]          trial;
  logic                       trial_ge;
  logic [SAMPLE_BITS-1:0]     quo_lo;

  assign full    = (fill_r >= len_r);
  assign ptr_inc = CNT_BITS'(ptr_r) + CNT_BITS'(1);
  assign new_ext = {{(SUM_BITS-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign old_ext = {{(SUM_BITS-SAMPLE_BITS){rd_data_r[SAMPLE_BITS-1]}}, rd_data_r};

  // running sum with the overwritten sample removed once full
  always_comb begin
    if (full) begin
      sum_nxt = sum_r + new_ext - old_ext;
    end else begin
      sum_nxt = sum_r + new_ext;
    end
  end

  // sample ring, read at request time, written on update
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r  <= in_sample;
      rd_data_r <= ring_mem[ptr_r];
    end
    if (cmd.update) begin
      ring_mem[ptr_r] <= sample_r;
    end
  end

  // window state: length, pointer, fill count and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= eff_len(mavg_pkg::LEN_RESET);
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cfg_valid) begin
      len_r  <= eff_len(cfg_window_length);
      ptr_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (cmd.update) begin
      sum_r <= sum_nxt;
      if (!full) begin
        fill_r <= fill_r + CNT_BITS'(1);
      end
      if (ptr_inc >= len_r) begin
        ptr_r <= '0;
      end else begin
        ptr_r <= PTR_BITS'(ptr_inc);
      end
    end
  end

  // restoring divide of the sum magnitude by the fill count
  assign trial    = {rem_r, quo_r[SUM_BITS-1]} - {1'b0, fill_r};
  assign trial_ge = ({rem_r, quo_r[SUM_BITS-1]} >= {1'b0, fill_r});

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      neg_r  <= sum_r[SUM_BITS-1];
      quo_r  <= sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);
      rem_r  <= '0;
      step_r <= STEP_BITS'(SUM_BITS - 1);
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_BITS-2:0], trial_ge};
      rem_r  <= trial_ge ? trial[CNT_BITS-1:0] : {rem_r[CNT_BITS-2:0], quo_r[SUM_BITS-1]};
      step_r <= step_r - STEP_BITS'(1);
    end
  end

  assign quo_lo = quo_r[SAMPLE_BITS-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_average_r <= neg_r ? signed'(-quo_lo) : signed'(quo_lo);
      out_full_r    <= full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_average_r;
  assign out_window_full = out_full_r;

  assign status.div_last = (step_r == '0);
  assign status.out_busy = out_valid_r && !out_ready;

endmodule
`default_nettype wire

// File: rtl/moving_average_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average filter
// Simple moving average over a ring of the most recent signed samples.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one signed sample per request, valid/ready handshake.
//   out_* : one result per request: sum divided by the fill count
//           (truncated toward zero) and a window full flag.
//   cfg_* : write of the window length; always ready. A write clears the
//           ring pointer, fill count and running sum; write only while idle.
//   Sequence: from input acceptance to out_valid a request passes through
//   accept, ring update, divider setup, the serial divider (one sum bit per
//   cycle) and output load. One request is in flight at a time, so a new
//   sample is taken only once the previous result has been loaded into the
//   output register.
//   Reset: window length 8, pointer, fill count and running sum cleared,
//   output register empty. Ring entries are only read once written.
//   Receiver stall: the result waits in the output register; the next
//   sample is still accepted and computed, and waits before its load.
// ----------------------------------------------------------------------------
module moving_average_filter #(
  parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [mavg_pkg::CFG_LEN_BITS-1:0] cfg_window_length,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_average,
  output logic                              out_window_full
);

  mavg_pkg::mavg_cmd_t    cmd;
  mavg_pkg::mavg_status_t status;

  assign cfg_ready = 1'b1;

  // controller
  mavg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  mavg_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_window_length (cfg_window_length),
    .in_sample         (in_sample),
    .out_average       (out_average),
    .out_window_full   (out_window_full),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
`default_nettype wire

// File: tb/moving_average_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter checker
// Watches the sample, result and window length channels. It keeps its own
// copy of the sample ring and running sum, works out the expected average
// and window full flag for every accepted sample, and compares each
// accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module moving_average_filter_checker (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        cfg_valid,
  input  wire                                        cfg_ready,
  input  wire  [mavg_pkg::CFG_LEN_BITS-1:0]          cfg_window_length,
  input  wire                                        in_valid,
  input  wire                                        in_ready,
  input  wire  signed [mavg_pkg::SAMPLE_BITS_DEF-1:0] in_sample,
  input  wire                                        out_valid,
  input  wire                                        out_ready,
  input  wire  signed [mavg_pkg::SAMPLE_BITS_DEF-1:0] out_average,
  input  wire                                        out_window_full,
  output int                                         error_count,
  output int                                         pending_count,
  output int                                         result_count
);

  localparam int WIN_MAX    = mavg_pkg::WINDOW_MAX_DEF;
  localparam int SMP_BITS   = mavg_pkg::SAMPLE_BITS_DEF;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic signed [SMP_BITS-1:0] average;
    logic                       window_full;
  } average_result_t;

  // model of the window
  logic signed [SMP_BITS-1:0] ring_copy [WIN_MAX];
  int unsigned                slot;
  int unsigned                fill;
  int unsigned                span;
  longint                     window_sum;

  average_result_t expected_averages [$];
  int mismatch_total = 0;
  int checked_total  = 0;

  // window length register value to effective length
  function automatic int unsigned clamp_length(input logic [mavg_pkg::CFG_LEN_BITS-1:0] raw);
    if (raw == 0) return 1;
    if (raw > WIN_MAX) return WIN_MAX;
    return raw;
  endfunction

  task automatic clear_window();
    for (int k = 0; k < WIN_MAX; k++) ring_copy[k] = '0;
    slot       = 0;
    fill       = 0;
    window_sum = 0;
  endtask

  // add one sample to the window and work out its average
  task automatic advance_window(input logic signed [SMP_BITS-1:0] s,
                                output average_result_t r);
    longint quotient;
    if (slot >= span) slot = 0;
    if (fill >= span) window_sum -= ring_copy[slot];
    else fill++;
    ring_copy[slot] = s;
    window_sum += s;
    slot++;
    if (slot >= span) slot = 0;
    // signed division truncates toward zero
    quotient      = window_sum / longint'(fill);
    r.average     = quotient[SMP_BITS-1:0];
    r.window_full = (fill >= span);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_total++;
    if (mismatch_total <= MAX_PRINTS) $display("mavg check: %s", msg);
  endtask

  // compare, then track configuration and new requests
  always @(posedge clk) begin
    average_result_t got;
    average_result_t want;
    if (!rst_n) begin
      span = clamp_length(mavg_pkg::LEN_RESET);
      clear_window();
      expected_averages.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.average     = out_average;
        got.window_full = out_window_full;
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("result with none pending: average %0d full %0b",
                                    $signed(got.average), got.window_full));
        end else begin
          want = expected_averages.pop_front();
          checked_total++;
          if (got.average !== want.average)
            report_mismatch($sformatf("result %0d: average %0d, expected %0d", checked_total,
                                      $signed(got.average), $signed(want.average)));
          if (got.window_full !== want.window_full)
            report_mismatch($sformatf("result %0d: window full %0b, expected %0b",
                                      checked_total, got.window_full, want.window_full));
        end
      end
      if (cfg_valid && cfg_ready) begin
        span = clamp_length(cfg_window_length);
        clear_window();
      end
      if (in_valid && in_ready) begin
        advance_window(in_sample, want);
        expected_averages.push_back(want);
      end
    end
    error_count   <= mismatch_total;
    pending_count <= expected_averages.size();
    result_count  <= checked_total;
  end

endmodule

// File: tb/moving_average_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter test
// Drives samples in random bursts against a receiver that stalls on its
// own pattern, steps the window length through its extremes between
// phases, and leaves checking to the checker beside the filter.
// ----------------------------------------------------------------------------
module moving_average_filter_test;

  localparam int SMP_BITS        = mavg_pkg::SAMPLE_BITS_DEF;
  localparam int LEN_BITS        = mavg_pkg::CFG_LEN_BITS;
  localparam int ITEMS_PER_PHASE = 88;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 600;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic                       clk;
  logic                       rst_n             = 1'b0;
  logic                       cfg_valid         = 1'b0;
  logic [LEN_BITS-1:0]        cfg_window_length = '0;
  logic                       in_valid          = 1'b0;
  logic signed [SMP_BITS-1:0] in_sample         = '0;
  logic                       out_ready         = 1'b0;
  wire                        cfg_ready;
  wire                        in_ready;
  wire                        out_valid;
  wire signed [SMP_BITS-1:0]  out_average;
  wire                        out_window_full;

  int error_count;
  int pending_count;
  int result_count;

  // sender burst state
  int unsigned                burst_left    = 0;
  logic signed [SMP_BITS-1:0] prev_sample   = '0;
  int unsigned                sample_total  = 0;
  int unsigned                setting_total = 0;
  int unsigned                stall_cycles  = 0;

  // toggled to ask the receiver for one long hold-off
  logic hold_token = 1'b0;

  logic signed [SMP_BITS-1:0] directed_samples [18] = '{
    16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh5555, 16'shAAAA,
    16'sh8000, 16'sh7FFF, 16'shFFFF,
    16'sh0001, 16'shFFFF,
    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000
  };

  logic [LEN_BITS-1:0] phase_lengths [9] = '{
    7'd64, 7'd127, 7'd1, 7'd65, 7'd3, 7'd0, 7'd8, 7'd33, 7'd2
  };

  moving_average_filter u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_average       (out_average),
    .out_window_full   (out_window_full)
  );

  moving_average_filter_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_average       (out_average),
    .out_window_full   (out_window_full),
    .error_count       (error_count),
    .pending_count     (pending_count),
    .result_count      (result_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random sample with a bias toward full scale, small values and repeats
  function automatic logic signed [SMP_BITS-1:0] draw_sample();
    logic signed [SMP_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = SMP_BITS'($urandom);
      4:          v = 16'sh7FFF;
      5:          v = 16'sh8000;
      6:          v = SMP_BITS'($urandom_range(0, 16)) - 16'sd8;
      7:          v = prev_sample;
      8:          v = {1'b1, 15'($urandom_range(0, 255))};
      default:    v = {1'b0, ~15'($urandom_range(0, 255))};
    endcase
    prev_sample = v;
    return v;
  endfunction

  // offer one sample request, opening a new burst after a random gap
  task automatic offer_sample(input logic signed [SMP_BITS-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:       gap = 0;
        2, 3, 4, 5: gap = $urandom_range(1, 8);
        6:          gap = $urandom_range(9, 40);
        default:    gap = $urandom_range(41, 80);
      endcase
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (!in_ready);
    sample_total++;
  endtask

  // stop offering and wait until the filter has nothing in flight
  task automatic settle_phase();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [LEN_BITS-1:0] len);
    cfg_valid         <= 1'b1;
    cfg_window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    setting_total++;
  endtask

  // receiver: segments of steady, random, sparse or patterned readiness
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned idx;
    logic [7:0]  stall_mask;
    logic        hold_seen;
    hold_seen = 1'b0;
    idx       = 0;
    forever begin
      mode       = $urandom_range(0, 3);
      seg        = $urandom_range(20, 200);
      stall_mask = 8'($urandom);
      repeat (seg) begin
        @(posedge clk);
        if (hold_token != hold_seen) begin
          hold_seen = hold_token;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: begin
            out_ready <= stall_mask[idx % 8];
            idx++;
          end
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a request", stall_cycles);
      $display("moving_average_filter_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned         i;
    int unsigned         p;
    logic [LEN_BITS-1:0] setting;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset length of eight filled and wrapped
    for (i = 0; i < 9; i++) offer_sample(directed_samples[i]);
    settle_phase();
    // zero length behaves as one
    write_window('0);
    for (i = 9; i < 12; i++) offer_sample(directed_samples[i]);
    settle_phase();
    // same effective length again still clears
    write_window(7'd1);
    for (i = 12; i < 14; i++) offer_sample(directed_samples[i]);
    settle_phase();
    // full window of negative full scale
    write_window(7'd2);
    for (i = 14; i < 18; i++) offer_sample(directed_samples[i]);
    settle_phase();

    // random phases over the length extremes and a random length
    for (p = 0; p < 9; p++) begin
      setting = (p == 8) ? LEN_BITS'($urandom_range(2, 63)) : phase_lengths[p];
      write_window(setting);
      if (p == 0) hold_token <= ~hold_token;
      for (i = 0; i < ITEMS_PER_PHASE; i++) offer_sample(draw_sample());
      settle_phase();
    end

    $display("covered %0d samples across %0d window length writes, %0d results compared",
             sample_total, setting_total, result_count);
    $display("lengths ran from zero and one through 64 and saturated values up to 127");
    if (error_count == 0) begin
      $display("moving_average_filter_test: clean");
    end else begin
      $display("moving_average_filter_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mavg_pkg.sv
rtl/mavg_ctrl.sv
rtl/mavg_dp.sv
rtl/moving_average_filter.sv
tb/moving_average_filter_checker.sv
tb/moving_average_filter_test.sv
